// ----- rtl/core/pttp_pkg.sv -----
// Shared types, widths, register codes and reset values for the tone period controller.
package pttp_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int FREQ_W     = 10;
  localparam int DB_W       = 8;
  localparam int CPT_W      = 24;
  localparam int NUM_W      = 36;
  localparam int DEN_W      = 22;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int WINDOW_LEN_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LO_THRESH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HI_THRESH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LO         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HI         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PER_TABLE = 3'd5;

  localparam logic [SAMPLE_W-1:0] LO_THRESH_RST       = 12'd192;
  localparam logic [SAMPLE_W-1:0] HI_THRESH_RST       = 12'd3170;
  localparam logic [FREQ_W-1:0]   FREQ_LO_RST         = 10'd1;
  localparam logic [FREQ_W-1:0]   FREQ_HI_RST         = 10'd30;
  localparam logic [DB_W-1:0]     DEAD_BAND_RST       = 8'd2;
  localparam logic [CPT_W-1:0]    CLOCK_PER_TABLE_RST = 24'd31250;

  localparam logic [CPT_W-1:0] RELOAD_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                start;
    logic                stop;
    logic                write;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
  } pttp_job_t;

  typedef enum logic [2:0] {
    F_ACC,
    F_MEAN,
    F_CLASS,
    F_MUL_NUM,
    F_MUL_A,
    F_MUL_B,
    F_PUSH
  } pttp_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIN,
    B_OUT
  } pttp_back_state_t;

endpackage

// ----- rtl/core/pttp_front.sv -----
// Front end: configuration registers, window accumulation, mean and reload operands.
module pttp_front #(
  parameter int WINDOW_LEN = pttp_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pttp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pttp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pttp_pkg::SAMPLE_W-1:0]       in_adc_sample,
  output logic                                job_valid,
  input  logic                                job_ready,
  output pttp_pkg::pttp_job_t                 job
);

  localparam int CNT_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = pttp_pkg::SAMPLE_W + CNT_W;
  localparam int REC_K  = SUM_W + CNT_W;
  localparam int REC_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + REC_W;
  localparam int unsigned REC_M_INT = ((32'd1 << REC_K) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [REC_W-1:0] REC_M = REC_W'(REC_M_INT);
  localparam int SW = pttp_pkg::SAMPLE_W;
  localparam int NW = pttp_pkg::NUM_W;
  localparam int DW = pttp_pkg::DEN_W;

  logic [SW-1:0]              lo_thresh_r;
  logic [SW-1:0]              hi_thresh_r;
  logic [pttp_pkg::FREQ_W-1:0] freq_lo_r;
  logic [pttp_pkg::FREQ_W-1:0] freq_hi_r;
  logic [pttp_pkg::DB_W-1:0]   dead_band_r;
  logic [pttp_pkg::CPT_W-1:0]  clock_per_table_r;

  pttp_pkg::pttp_front_state_t state_r, state_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             stopped_r, stopped_nxt;
  logic [SW-1:0]    last_mean_r, last_mean_nxt;

  logic [SUM_W-1:0] hold_sum_r, hold_sum_nxt;
  logic [SW-1:0]    mean_r, mean_nxt;
  logic             start_r, start_nxt;
  logic             stop_r, stop_nxt;
  logic             write_r, write_nxt;
  logic [SW-1:0]    sp_r, sp_nxt;
  logic [SW-1:0]    a_r, a_nxt;
  logic [SW-1:0]    b_r, b_nxt;
  logic [NW-1:0]    num_r, num_nxt;
  logic [DW-1:0]    den_r, den_nxt;

  logic [SUM_W-1:0]  sum_add;
  logic [PROD_W-1:0] mean_prod;
  logic [SW-1:0]     diff;
  logic [SW-1:0]     span_w;
  logic [SW-1:0]     d_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_thresh_r       <= pttp_pkg::LO_THRESH_RST;
      hi_thresh_r       <= pttp_pkg::HI_THRESH_RST;
      freq_lo_r         <= pttp_pkg::FREQ_LO_RST;
      freq_hi_r         <= pttp_pkg::FREQ_HI_RST;
      dead_band_r       <= pttp_pkg::DEAD_BAND_RST;
      clock_per_table_r <= pttp_pkg::CLOCK_PER_TABLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pttp_pkg::REG_LO_THRESH:       lo_thresh_r       <= cfg_wdata[SW-1:0];
        pttp_pkg::REG_HI_THRESH:       hi_thresh_r       <= cfg_wdata[SW-1:0];
        pttp_pkg::REG_FREQ_LO:         freq_lo_r         <= cfg_wdata[pttp_pkg::FREQ_W-1:0];
        pttp_pkg::REG_FREQ_HI:         freq_hi_r         <= cfg_wdata[pttp_pkg::FREQ_W-1:0];
        pttp_pkg::REG_DEAD_BAND:       dead_band_r       <= cfg_wdata[pttp_pkg::DB_W-1:0];
        pttp_pkg::REG_CLOCK_PER_TABLE: clock_per_table_r <= cfg_wdata[pttp_pkg::CPT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pttp_pkg::F_ACC;
      sum_r       <= '0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      last_mean_r <= '0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      stopped_r   <= stopped_nxt;
      last_mean_r <= last_mean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_sum_r <= hold_sum_nxt;
    mean_r     <= mean_nxt;
    start_r    <= start_nxt;
    stop_r     <= stop_nxt;
    write_r    <= write_nxt;
    sp_r       <= sp_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
  end

  assign sum_add   = sum_r + SUM_W'(in_adc_sample);
  assign mean_prod = PROD_W'(hold_sum_r) * PROD_W'(REC_M);
  assign diff      = (mean_r >= last_mean_r) ? (mean_r - last_mean_r) : (last_mean_r - mean_r);
  assign span_w    = hi_thresh_r - lo_thresh_r;
  assign d_w       = mean_r - SW'(1) - lo_thresh_r;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    stopped_nxt   = stopped_r;
    last_mean_nxt = last_mean_r;
    hold_sum_nxt  = hold_sum_r;
    mean_nxt      = mean_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    write_nxt     = write_r;
    sp_nxt        = sp_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    in_ready      = 1'b0;
    job_valid     = 1'b0;

    unique case (state_r)
      pttp_pkg::F_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r == CNT_W'(WINDOW_LEN - 1)) begin
            hold_sum_nxt = sum_add;
            sum_nxt      = '0;
            cnt_nxt      = '0;
            state_nxt    = pttp_pkg::F_MEAN;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      pttp_pkg::F_MEAN: begin
        mean_nxt  = mean_prod[REC_K +: SW];
        state_nxt = pttp_pkg::F_CLASS;
      end
      pttp_pkg::F_CLASS: begin
        start_nxt = 1'b0;
        stop_nxt  = 1'b0;
        write_nxt = 1'b0;
        if (mean_r > lo_thresh_r) begin
          start_nxt     = stopped_r;
          stopped_nxt   = 1'b0;
          last_mean_nxt = mean_r;
          write_nxt     = diff > SW'(dead_band_r);
          if ((hi_thresh_r <= lo_thresh_r) || (mean_r > hi_thresh_r)) begin
            sp_nxt = SW'(1);
            a_nxt  = '0;
            b_nxt  = SW'(1);
          end else begin
            sp_nxt = span_w;
            a_nxt  = span_w - d_w;
            b_nxt  = d_w;
          end
        end else begin
          stop_nxt    = !stopped_r;
          stopped_nxt = 1'b1;
        end
        state_nxt = write_nxt ? pttp_pkg::F_MUL_NUM : pttp_pkg::F_PUSH;
      end
      pttp_pkg::F_MUL_NUM: begin
        num_nxt   = NW'(clock_per_table_r) * NW'(sp_r);
        state_nxt = pttp_pkg::F_MUL_A;
      end
      pttp_pkg::F_MUL_A: begin
        den_nxt   = DW'(freq_lo_r) * DW'(a_r);
        state_nxt = pttp_pkg::F_MUL_B;
      end
      pttp_pkg::F_MUL_B: begin
        den_nxt   = den_r + DW'(freq_hi_r) * DW'(b_r);
        state_nxt = pttp_pkg::F_PUSH;
      end
      pttp_pkg::F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_nxt = pttp_pkg::F_ACC;
        end
      end
      default: begin
        state_nxt = pttp_pkg::F_ACC;
      end
    endcase
  end

  assign job.mean  = mean_r;
  assign job.start = start_r;
  assign job.stop  = stop_r;
  assign job.write = write_r;
  assign job.num   = num_r;
  assign job.den   = den_r;

endmodule

// ----- rtl/core/pttp_fifo.sv -----
// Short job queue between the front end and the divider back end.
module pttp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  pttp_pkg::pttp_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pttp_pkg::pttp_job_t pop_data
);

  localparam int DEPTH = pttp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pttp_pkg::pttp_job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/pttp_back.sv -----
// Back end: bit-serial reload division and the registered result word.
module pttp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  pttp_pkg::pttp_job_t                 job,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pttp_pkg::SAMPLE_W-1:0]       out_mean_value,
  output logic                                out_start_output,
  output logic                                out_stop_output,
  output logic                                out_reload_write,
  output logic [pttp_pkg::CPT_W-1:0]          out_reload_value
);

  localparam int NW = pttp_pkg::NUM_W;
  localparam int DW = pttp_pkg::DEN_W;
  localparam int CW = pttp_pkg::DIV_CNT_W;
  localparam int RW = pttp_pkg::CPT_W;

  pttp_pkg::pttp_back_state_t state_r, state_nxt;
  logic [CW-1:0] step_r, step_nxt;

  logic [NW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  den_r, den_nxt;
  logic [pttp_pkg::SAMPLE_W-1:0] mean_r, mean_nxt;
  logic           start_r, start_nxt;
  logic           stop_r, stop_nxt;
  logic           write_r, write_nxt;
  logic [RW-1:0]  reload_r, reload_nxt;

  logic [DW:0]    trial;
  logic           fits;
  logic [NW-1:0]  quo_m1;

  assign trial  = {rem_r, quo_r[NW-1]};
  assign fits   = trial >= {1'b0, den_r};
  assign quo_m1 = quo_r - NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pttp_pkg::B_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    mean_r   <= mean_nxt;
    start_r  <= start_nxt;
    stop_r   <= stop_nxt;
    write_r  <= write_nxt;
    reload_r <= reload_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    mean_nxt   = mean_r;
    start_nxt  = start_r;
    stop_nxt   = stop_r;
    write_nxt  = write_r;
    reload_nxt = reload_r;
    job_ready  = 1'b0;
    out_valid  = 1'b0;

    unique case (state_r)
      pttp_pkg::B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          mean_nxt  = job.mean;
          start_nxt = job.start;
          stop_nxt  = job.stop;
          write_nxt = job.write;
          quo_nxt   = job.num;
          den_nxt   = job.den;
          rem_nxt   = '0;
          step_nxt  = '0;
          if (!job.write) begin
            reload_nxt = '0;
            state_nxt  = pttp_pkg::B_OUT;
          end else if (job.den == '0) begin
            reload_nxt = pttp_pkg::RELOAD_MAX;
            state_nxt  = pttp_pkg::B_OUT;
          end else begin
            state_nxt = pttp_pkg::B_DIV;
          end
        end
      end
      pttp_pkg::B_DIV: begin
        rem_nxt  = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        quo_nxt  = {quo_r[NW-2:0], fits};
        step_nxt = step_r + CW'(1);
        if (step_r == CW'(NW - 1)) begin
          state_nxt = pttp_pkg::B_FIN;
        end
      end
      pttp_pkg::B_FIN: begin
        if (quo_r == '0) begin
          reload_nxt = '0;
        end else if (|quo_m1[NW-1:RW]) begin
          reload_nxt = pttp_pkg::RELOAD_MAX;
        end else begin
          reload_nxt = quo_m1[RW-1:0];
        end
        state_nxt = pttp_pkg::B_OUT;
      end
      pttp_pkg::B_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = pttp_pkg::B_IDLE;
        end
      end
    endcase
  end

  assign out_mean_value   = mean_r;
  assign out_start_output = start_r;
  assign out_stop_output  = stop_r;
  assign out_reload_write = write_r;
  assign out_reload_value = reload_r;

endmodule

// ----- rtl/core/pot_to_tone_period_controller.sv -----
// Top level of the potentiometer to tone period controller.
// Samples take one word per cycle while in_ready is high; a window-end word holds it low
// while its mean and class and, for a new reload, its operands are formed, and until the
// queue takes the job. Only a reload job goes through the 36-step back-end divider.
// A two-entry job queue lets the next window accumulate while the divider works.
// Synchronous reset clears the window, the run/stop state, the queue and the configuration.
module pot_to_tone_period_controller #(
  parameter int WINDOW_LEN = pttp_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pttp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pttp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pttp_pkg::SAMPLE_W-1:0]       in_adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pttp_pkg::SAMPLE_W-1:0]       out_mean_value,
  output logic                                out_start_output,
  output logic                                out_stop_output,
  output logic                                out_reload_write,
  output logic [pttp_pkg::CPT_W-1:0]          out_reload_value
);

  logic                push_valid;
  logic                push_ready;
  pttp_pkg::pttp_job_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  pttp_pkg::pttp_job_t pop_data;

  pttp_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_adc_sample(in_adc_sample),
    .job_valid    (push_valid),
    .job_ready    (push_ready),
    .job          (push_data)
  );

  pttp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  pttp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (pop_valid),
    .job_ready       (pop_ready),
    .job             (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mean_value  (out_mean_value),
    .out_start_output(out_start_output),
    .out_stop_output (out_stop_output),
    .out_reload_write(out_reload_write),
    .out_reload_value(out_reload_value)
  );

endmodule
